@@ rtl/spcc_pkg.sv @@
// ----------------------------------------------------------------------------
// spcc_pkg
// Shared types, sizes and helpers of the segment versus polygon crossing check.
// ----------------------------------------------------------------------------
`default_nettype none

package spcc_pkg;

   // Table depth and coordinate precision.
   localparam int VERTEX_DEPTH = 256;
   localparam int COORD_WIDTH  = 24;

   // Width of the coordinate fields on the ports.
   localparam int FIELD_W = 24;
   // Coordinates keep their low HELD_W bits, sign extended.
   localparam int HELD_W  = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
   localparam int DIFF_W  = HELD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int WIDE_W  = PROD_W + 1;

   localparam int ADDR_W  = $clog2(VERTEX_DEPTH);
   localparam int CNT_W   = $clog2(VERTEX_DEPTH + 1);

   // Operation codes.
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   typedef logic signed [HELD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         count_type;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [FIELD_W-1:0] point_x;
      logic signed [FIELD_W-1:0] point_y;
      logic signed [FIELD_W-1:0] end_x;
      logic signed [FIELD_W-1:0] end_y;
      logic                      closes_polygon;
   } req_type;

   typedef struct packed {
      logic crossed;
      logic status;
   } rsp_type;

   // One table entry.
   typedef struct packed {
      logic      mark;
      coord_type y;
      coord_type x;
   } vertex_type;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      vertex_type data;
   } mem_wr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } mem_rd_type;

   // Query segment, held for the whole walk.
   typedef struct packed {
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
   } seg_type;

   // One polygon edge handed to the test pipeline.
   typedef struct packed {
      logic      valid;
      coord_type x3;
      coord_type y3;
      coord_type x4;
      coord_type y4;
   } edge_req_type;

   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit;
   } edge_stat_type;

   function automatic coord_type to_coord(input logic signed [FIELD_W-1:0] raw);
      return coord_type'(raw[HELD_W-1:0]);
   endfunction

   // True when num / den lies in [0,1]; den is nonzero.
   function automatic logic in_unit(input wide_type num, input wide_type den);
      logic result;
      if (den > wide_type'(0)) begin
         result = (num >= wide_type'(0)) && (num <= den);
      end else begin
         result = (num <= wide_type'(0)) && (num >= den);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ rtl/segment_polygon_crossing_check.sv @@
// ----------------------------------------------------------------------------
// segment_polygon_crossing_check
// Polygon outline table with a query that tests a segment against every edge.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                    Handshake
//   request   req_item                 taken when start is high and busy is low
//   response  rsp_item, rsp_valid      shown for one cycle, cannot be held off
//
// Clear, append and unused codes answer in the cycle after the item is taken,
// and busy stays low, so such items can follow each other in every cycle.
// A query of a table holding n vertices walks the vertex memory one entry per
// cycle and keeps busy high through the n reads, the last returned vertex,
// the closing edge of the last polygon, the five stages of the edge pipeline
// and a check that sees the pipeline empty. Closing edges of earlier
// polygons ride in the slot that each new polygon's first vertex leaves free,
// so the number of polygons adds nothing to the walk. The answer shows in the
// cycle busy falls. An empty table answers a query in the cycle after it is
// taken. Reset clears the vertex count and the controller only; the table
// contents are not cleared.
//
// ----------------------------------------------------------------------------
`default_nettype none

module segment_polygon_crossing_check
   import spcc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_item,
   output      logic    rsp_valid,
   output      rsp_type rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   count_type rd_idx_ff, rd_idx_in;
   logic      ret_valid_ff, ret_valid_in;
   logic      ret_final_ff, ret_final_in;
   logic      start_ff, start_in;     // next returned vertex opens a polygon
   logic      pend_ff, pend_in;       // closing edge still to be issued
   logic      crossed_ff, crossed_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_item_ff, rsp_item_in;
   seg_type   seg_ff, seg_in;
   vertex_type prev_ff, prev_in;
   vertex_type first_ff, first_in;

   mem_wr_type    mem_wr;
   mem_rd_type    mem_rd;
   vertex_type    cur;
   edge_req_type  edge_req;
   edge_stat_type edge_stat;
   logic          accept;
   logic          cur_last;

   spcc_vertex_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (cur)
   );

   spcc_edge_pipe u_edge (
      .clock    (clock),
      .reset    (reset),
      .seg      (seg_ff),
      .edge_req (edge_req),
      .stat     (edge_stat)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      ret_valid_in = 1'b0;
      ret_final_in = 1'b0;
      start_in     = start_ff;
      pend_in      = 1'b0;
      crossed_in   = crossed_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      seg_in       = seg_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;

      mem_wr       = '0;
      mem_rd       = '0;
      edge_req     = '0;
      cur_last     = cur.mark | ret_final_ff;

      // Returned vertex. The entry after a polygon's last vertex always opens
      // a new polygon and issues no edge of its own, which frees that cycle
      // for the closing edge of the polygon just finished.
      if (pend_ff) begin
         edge_req.valid = 1'b1;
         edge_req.x3    = prev_ff.x;
         edge_req.y3    = prev_ff.y;
         edge_req.x4    = first_ff.x;
         edge_req.y4    = first_ff.y;
      end else if (ret_valid_ff && !start_ff) begin
         edge_req.valid = 1'b1;
         edge_req.x3    = prev_ff.x;
         edge_req.y3    = prev_ff.y;
         edge_req.x4    = cur.x;
         edge_req.y4    = cur.y;
      end

      if (ret_valid_ff) begin
         prev_in  = cur;
         if (start_ff) begin
            first_in = cur;
         end
         start_in = cur_last;
         // A polygon of one vertex issues no edge at all, so it never crosses.
         pend_in  = cur_last && !start_ff;
      end

      if (edge_stat.hit_valid && edge_stat.hit) begin
         crossed_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_item_in = '0;
               case (req_item.opcode)
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < CNT_W'(VERTEX_DEPTH)) begin
                        mem_wr.en     = 1'b1;
                        mem_wr.addr   = count_ff[ADDR_W-1:0];
                        mem_wr.data.x = to_coord(req_item.point_x);
                        mem_wr.data.y = to_coord(req_item.point_y);
                        mem_wr.data.mark = req_item.closes_polygon;
                        count_in      = count_ff + CNT_W'(1);
                     end else begin
                        rsp_item_in.status = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        seg_in.x1  = to_coord(req_item.point_x);
                        seg_in.y1  = to_coord(req_item.point_y);
                        seg_in.x2  = to_coord(req_item.end_x);
                        seg_in.y2  = to_coord(req_item.end_y);
                        rd_idx_in  = '0;
                        start_in   = 1'b1;
                        crossed_in = 1'b0;
                        state_in   = ST_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            mem_rd.en    = 1'b1;
            mem_rd.addr  = rd_idx_ff[ADDR_W-1:0];
            ret_valid_in = 1'b1;
            ret_final_in = (rd_idx_ff == count_ff - CNT_W'(1));
            rd_idx_in    = rd_idx_ff + CNT_W'(1);
            if (ret_final_in) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Done once the last vertex, its closing edge and every edge in
            // the pipeline have been seen.
            if (!ret_valid_ff && !pend_ff && !edge_stat.busy) begin
               rsp_valid_in        = 1'b1;
               rsp_item_in.crossed = crossed_ff;
               rsp_item_in.status  = 1'b0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ret_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ret_valid_ff <= ret_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      ret_final_ff <= ret_final_in;
      start_ff     <= start_in;
      crossed_ff   <= crossed_in;
      rsp_item_ff  <= rsp_item_in;
      seg_ff       <= seg_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

@@ rtl/spcc_vertex_mem.sv @@
// ----------------------------------------------------------------------------
// spcc_vertex_mem
// Vertex table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spcc_vertex_mem
   import spcc_pkg::*;
(
   input  wire logic       clock,
   input  wire mem_wr_type wr,
   input  wire mem_rd_type rd,
   output      vertex_type rd_data
);

   vertex_type mem_ff [VERTEX_DEPTH];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/spcc_edge_pipe.sv @@
// ----------------------------------------------------------------------------
// spcc_edge_pipe
// Five-stage crossing test of one polygon edge against the query segment.
// ----------------------------------------------------------------------------
`default_nettype none

module spcc_edge_pipe
   import spcc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire seg_type       seg,
   input  wire edge_req_type  edge_req,
   output      edge_stat_type stat
);

   // Stage 0: edge endpoints.
   logic      v0_ff;
   coord_type x3_ff, y3_ff, x4_ff, y4_ff;
   // Stage 1: differences and box test.
   logic      v1_ff, box1_ff;
   diff_type  dx1_ff, dy1_ff, dx2_ff, dy2_ff, ox_ff, oy_ff;
   // Stage 2: products.
   logic      v2_ff, box2_ff;
   prod_type  pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   // Stage 3: denominator and numerators.
   logic      v3_ff, box3_ff;
   wide_type  den_ff, na_ff, nb_ff;
   // Stage 4: verdict.
   logic      v4_ff, hit_ff;

   logic box_x_out, box_y_out, box_in, hit_in;

   always_comb begin
      // Boxes miss when every coordinate of one lies below every one of the other.
      box_x_out = (seg.x1 < x3_ff && seg.x1 < x4_ff && seg.x2 < x3_ff && seg.x2 < x4_ff) ||
                  (x3_ff < seg.x1 && x3_ff < seg.x2 && x4_ff < seg.x1 && x4_ff < seg.x2);
      box_y_out = (seg.y1 < y3_ff && seg.y1 < y4_ff && seg.y2 < y3_ff && seg.y2 < y4_ff) ||
                  (y3_ff < seg.y1 && y3_ff < seg.y2 && y4_ff < seg.y1 && y4_ff < seg.y2);
      box_in    = !box_x_out && !box_y_out;
      hit_in    = box3_ff && (den_ff != '0) &&
                  in_unit(na_ff, den_ff) && in_unit(nb_ff, den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= edge_req.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end

      x3_ff <= edge_req.x3;
      y3_ff <= edge_req.y3;
      x4_ff <= edge_req.x4;
      y4_ff <= edge_req.y4;

      box1_ff <= box_in;
      dx1_ff  <= diff_type'(seg.x2) - diff_type'(seg.x1);
      dy1_ff  <= diff_type'(seg.y2) - diff_type'(seg.y1);
      dx2_ff  <= diff_type'(x4_ff) - diff_type'(x3_ff);
      dy2_ff  <= diff_type'(y4_ff) - diff_type'(y3_ff);
      ox_ff   <= diff_type'(seg.x1) - diff_type'(x3_ff);
      oy_ff   <= diff_type'(seg.y1) - diff_type'(y3_ff);

      box2_ff <= box1_ff;
      pa_ff   <= prod_type'(dy2_ff) * prod_type'(dx1_ff);
      pb_ff   <= prod_type'(dx2_ff) * prod_type'(dy1_ff);
      pc_ff   <= prod_type'(dx2_ff) * prod_type'(oy_ff);
      pd_ff   <= prod_type'(dy2_ff) * prod_type'(ox_ff);
      pe_ff   <= prod_type'(dx1_ff) * prod_type'(oy_ff);
      pf_ff   <= prod_type'(dy1_ff) * prod_type'(ox_ff);

      box3_ff <= box2_ff;
      den_ff  <= wide_type'(pa_ff) - wide_type'(pb_ff);
      na_ff   <= wide_type'(pc_ff) - wide_type'(pd_ff);
      nb_ff   <= wide_type'(pe_ff) - wide_type'(pf_ff);

      hit_ff  <= hit_in;
   end

   assign stat.busy      = v0_ff | v1_ff | v2_ff | v3_ff | v4_ff;
   assign stat.hit_valid = v4_ff;
   assign stat.hit       = hit_ff;

endmodule

`default_nettype wire

@@ rtl/spcc_checker.sv @@
// ----------------------------------------------------------------------------
// spcc_checker
// Port-level checks of the crossing check, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spcc_checker
   import spcc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_item,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item
);

   // Items other than queries answer at once and never report a crossing.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.opcode != OP_QUERY |=> rsp_valid && !rsp_item.crossed)
      else $error("non-query item did not answer with crossed clear");

   // No answer shows while a query walks the table.
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("answer shown while busy");

   // The end of a walk always brings the query's answer.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("query ended without an answer");

   // Only an append can report a dropped vertex.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(start && !busy && req_item.opcode == OP_APPEND)
         |-> !rsp_item.status)
      else $error("status set on an answer that is not an append");

endmodule

bind segment_polygon_crossing_check spcc_checker u_checker (.*);

`default_nettype wire

@@ tb/segment_polygon_crossing_check_test.sv @@
// ----------------------------------------------------------------------------
// segment_polygon_crossing_check_test
// Self-checking bench for the segment versus polygon outline crossing check.
//
// A short table of directed items covers the empty table, the unused code, a
// closed square, a one-point polygon, an open trailing polygon, coordinate
// extremes and clearing. Random scenes follow: each builds a table of random
// polygons and fires queries at it, and a few fill the table past its depth.
// Every result is compared with a known answer or a model of the outline table.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_polygon_crossing_check_test;
   import spcc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 6;

   // Roughly how many counted items the run sends before it winds down.
   localparam int TOTAL_ITEMS = 1200;

   // The slowest correct run has every item a query of a full table, plus the
   // longest sender gaps; the limit allows more than that.
   localparam int CYCLE_LIMIT = 2_000_000;

   // A query of a full table is the longest the block can stay at work.
   localparam int DRAIN_CYCLES = 2 * VERTEX_DEPTH + 16;

   localparam int MAX_REPORTS = 10;

   // One unit in the 8-bit fraction fixed point format.
   localparam int U = 256;

   // The fourth code is not an operation; the block must answer it quietly.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic signed [FIELD_W-1:0] COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
   localparam logic signed [FIELD_W-1:0] COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

   localparam rsp_type QUIET = '{crossed: 1'b0, status: 1'b0};

   // One line of the directed table. When answer_known is set, the answer is
   // written into the table; otherwise the outline model supplies it.
   typedef struct {
      req_type item;
      bit      answer_known;
      rsp_type answer;
   } directed_row_type;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Bench copy of the outline table, updated as each item is accepted.
   longint outline_x [VERTEX_DEPTH];
   longint outline_y [VERTEX_DEPTH];
   bit     outline_closed [VERTEX_DEPTH];
   int     outline_count = 0;

   // Answers still owed by the block, oldest first.
   rsp_type expected_answers [$];

   int items_sent     = 0;
   int answers_seen   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   directed_row_type directed_rows [$];

   segment_polygon_crossing_check uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Outline model
   // ------------------------------------------------------------------------

   // The block keeps only the low HELD_W bits of a coordinate, sign extended.
   function automatic longint held_coord(input logic signed [FIELD_W-1:0] raw);
      coord_type held;
      held = raw[HELD_W-1:0];
      return longint'(held);
   endfunction

   // True when num / den lies in [0,1], judged by sign and magnitude alone.
   function automatic bit ratio_in_unit(input longint num, input longint den);
      if (den > 0) begin
         return (num >= 0) && (num <= den);
      end
      return (num <= 0) && (num >= den);
   endfunction

   // Segment (x1,y1)-(x2,y2) against one polygon side (x3,y3)-(x4,y4).
   function automatic bit side_is_crossed(input longint x1, input longint y1,
                                          input longint x2, input longint y2,
                                          input longint x3, input longint y3,
                                          input longint x4, input longint y4);
      longint dx1, dy1, dx2, dy2, ox, oy, den, na, nb;
      // Inclusive bounding boxes must overlap on both axes.
      if ((x1 > x2 ? x1 : x2) < (x3 < x4 ? x3 : x4)) return 1'b0;
      if ((x3 > x4 ? x3 : x4) < (x1 < x2 ? x1 : x2)) return 1'b0;
      if ((y1 > y2 ? y1 : y2) < (y3 < y4 ? y3 : y4)) return 1'b0;
      if ((y3 > y4 ? y3 : y4) < (y1 < y2 ? y1 : y2)) return 1'b0;
      dx1 = x2 - x1;
      dy1 = y2 - y1;
      dx2 = x4 - x3;
      dy2 = y4 - y3;
      ox  = x1 - x3;
      oy  = y1 - y3;
      den = dy2 * dx1 - dx2 * dy1;
      // Parallel or degenerate sides never count.
      if (den == 0) return 1'b0;
      na = dx2 * oy - dy2 * ox;
      nb = dx1 * oy - dy1 * ox;
      return ratio_in_unit(na, den) && ratio_in_unit(nb, den);
   endfunction

   // Walks every stored side. A vertex with a closing mark, or the last one
   // stored, wraps to the first vertex of its own polygon.
   function automatic bit segment_hits_outline(input longint x1, input longint y1,
                                                input longint x2, input longint y2);
      int first_idx;
      int next_idx;
      bit wraps;
      bit hit;
      first_idx = 0;
      hit       = 1'b0;
      for (int i = 0; i < outline_count && !hit; i++) begin
         wraps    = outline_closed[i] || (i + 1 == outline_count);
         next_idx = wraps ? first_idx : i + 1;
         hit = side_is_crossed(x1, y1, x2, y2, outline_x[i], outline_y[i],
                               outline_x[next_idx], outline_y[next_idx]);
         if (wraps) first_idx = i + 1;
      end
      return hit;
   endfunction

   // Applies one accepted item to the table copy and returns its answer.
   function automatic rsp_type apply_to_outline(input req_type item);
      rsp_type answer;
      answer = QUIET;
      case (item.opcode)
         OP_CLEAR: begin
            outline_count = 0;
         end
         OP_APPEND: begin
            if (outline_count < VERTEX_DEPTH) begin
               outline_x[outline_count]      = held_coord(item.point_x);
               outline_y[outline_count]      = held_coord(item.point_y);
               outline_closed[outline_count] = item.closes_polygon;
               outline_count++;
            end else begin
               // A full table drops the vertex and its mark.
               answer.status = 1'b1;
            end
         end
         OP_QUERY: begin
            answer.crossed = segment_hits_outline(held_coord(item.point_x),
                                                  held_coord(item.point_y),
                                                  held_coord(item.end_x),
                                                  held_coord(item.end_y));
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   // ------------------------------------------------------------------------
   // Item construction
   // ------------------------------------------------------------------------

   // A whole number of units as a coordinate field.
   function automatic logic signed [FIELD_W-1:0] units(input int n);
      return FIELD_W'(n * U);
   endfunction

   function automatic req_type make_item(input logic [1:0] op,
                                         input logic signed [FIELD_W-1:0] px,
                                         input logic signed [FIELD_W-1:0] py,
                                         input logic signed [FIELD_W-1:0] ex,
                                         input logic signed [FIELD_W-1:0] ey,
                                         input logic closes);
      req_type item;
      item.opcode         = op;
      item.point_x        = px;
      item.point_y        = py;
      item.end_x          = ex;
      item.end_y          = ey;
      item.closes_polygon = closes;
      return item;
   endfunction

   function automatic directed_row_type plan_row(input req_type item,
                                                 input bit known,
                                                 input rsp_type answer);
      directed_row_type line;
      line.item         = item;
      line.answer_known = known;
      line.answer       = answer;
      return line;
   endfunction

   // Appends one line to the directed table.
   function automatic void add_row(input req_type item, input bit known,
                                   input rsp_type answer);
      directed_rows.insert(directed_rows.size(), plan_row(item, known, answer));
   endfunction

   // Coordinate in one of three spans: a few units around the origin, where
   // sides and segments meet often; a wider window; or the full field with
   // its extremes showing up now and then.
   function automatic logic signed [FIELD_W-1:0] pick_coord(input int span);
      logic [31:0] raw;
      int          reach;
      raw = $urandom();
      if (span == 2) begin
         case ($urandom_range(0, 7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            default: return raw[FIELD_W-1:0];
         endcase
      end
      reach = (span == 0) ? 6 * U : (1 << 16);
      raw   = int'($urandom_range(0, 2 * reach)) - reach;
      return raw[FIELD_W-1:0];
   endfunction

   function automatic req_type random_bits_item();
      logic [127:0] raw;
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      return req_type'(raw[$bits(req_type)-1:0]);
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // The sender idles heavily in the first third of the run, even more in
   // the second, and not at all in the last.
   function automatic int sender_idle_percent();
      if (items_sent < TOTAL_ITEMS / 3) return 35;
      if (items_sent < 2 * TOTAL_ITEMS / 3) return 77;
      return 0;
   endfunction

   // Presents one item, holds it until the block takes it, and records the
   // answer that is then owed. start stays high into the next item when no
   // gap follows, so it is never lowered and raised in the same step.
   task automatic send_item(input req_type item, input bit answer_known,
                            input rsp_type known_answer);
      rsp_type predicted;
      int      idle_pct;
      idle_pct = sender_idle_percent();
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do begin
            // Junk on the data lines while start is low must be ignored.
            req_item <= random_bits_item();
            @(posedge clock);
         end while ($urandom_range(0, 99) < idle_pct);
      end
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      // The item was taken at this edge.
      predicted = apply_to_outline(item);
      expected_answers.insert(expected_answers.size(),
                              answer_known ? known_answer : predicted);
      if (item.opcode != OP_UNUSED) items_sent++;
   endtask

   // One random scene: usually clear the table, append random polygons, then
   // query. Most polygons close properly; a one-point polygon turns up now
   // and then, and the last polygon is sometimes left open. A fill scene
   // appends past the table depth to provoke dropped vertices.
   task automatic run_scene(input bit fill_table);
      int   span;
      int   query_span;
      int   vertex_total;
      int   query_total;
      int   poly_left;
      int   pick;
      int   idx;
      logic closes;
      logic signed [FIELD_W-1:0] px, py, ex, ey;
      span = ($urandom_range(0, 9) < 6) ? 0 : int'($urandom_range(1, 2));
      if (fill_table || $urandom_range(0, 4) != 0) begin
         send_item(make_item(OP_CLEAR, pick_coord(2), pick_coord(2), pick_coord(2),
                             pick_coord(2), 1'($urandom_range(0, 1))), 1'b0, QUIET);
      end
      vertex_total = fill_table ? VERTEX_DEPTH + int'($urandom_range(1, 3))
                                : int'($urandom_range(0, 24));
      poly_left = 0;
      for (int k = 0; k < vertex_total; k++) begin
         if (poly_left == 0) begin
            poly_left = ($urandom_range(0, 9) == 0) ? 1 : int'($urandom_range(2, 6));
         end
         poly_left--;
         closes = (poly_left == 0) && ((k + 1 < vertex_total) || ($urandom_range(0, 2) != 0));
         send_item(make_item(OP_APPEND, pick_coord(span), pick_coord(span), pick_coord(2),
                             pick_coord(2), closes), 1'b0, QUIET);
         if ($urandom_range(0, 19) == 0) begin
            send_item(make_item(OP_UNUSED, pick_coord(2), pick_coord(2), pick_coord(2),
                                pick_coord(2), 1'($urandom_range(0, 1))), 1'b0, QUIET);
         end
      end
      query_total = fill_table ? 4 : int'($urandom_range(3, 10));
      for (int q = 0; q < query_total; q++) begin
         query_span = ($urandom_range(0, 7) == 0) ? 2 : span;
         px = pick_coord(query_span);
         py = pick_coord(query_span);
         ex = pick_coord(query_span);
         ey = pick_coord(query_span);
         pick = $urandom_range(0, 9);
         if (pick < 2 && outline_count > 0) begin
            // Start exactly on a stored vertex: the inclusive boundary cases.
            idx = $urandom_range(0, outline_count - 1);
            px  = outline_x[idx][FIELD_W-1:0];
            py  = outline_y[idx][FIELD_W-1:0];
         end else if (pick == 2) begin
            ex = px;
            ey = py;
         end else if (pick == 3) begin
            ey = py;
         end else if (pick == 4) begin
            ex = px;
         end
         send_item(make_item(OP_QUERY, px, py, ex, ey, 1'($urandom_range(0, 1))),
                   1'b0, QUIET);
      end
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic note_mismatch(input string text);
      if (mismatch_count < MAX_REPORTS) $display("%0t ns: %s", $realtime, text);
      mismatch_count++;
   endtask

   // Results cannot be held off, so every strobe is one result to check.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            note_mismatch($sformatf("result %0d arrived with nothing outstanding", answers_seen));
         end else begin
            want = expected_answers.pop_front();
            if (rsp_item.crossed !== want.crossed || rsp_item.status !== want.status) begin
               note_mismatch($sformatf(
                  "result %0d: expected crossed %0b status %0b, got crossed %0b status %0b",
                  answers_seen, want.crossed, want.status, rsp_item.crossed, rsp_item.status));
            end
         end
         answers_seen++;
      end
   end

   // Watchdog: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("segment_polygon_crossing_check test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   initial begin
      int scene_index;

      // Empty table: any query answers with no crossing.
      add_row(make_item(OP_QUERY, units(-1), units(-1), units(1), units(1), 1'b0),
              1'b1, QUIET);
      // The unused code changes nothing and answers quietly.
      add_row(make_item(OP_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1),
              1'b1, QUIET);
      // A closed square from (0,0) to (4,4).
      add_row(make_item(OP_APPEND, units(0), units(0), units(0), units(0), 1'b0),
              1'b1, QUIET);
      add_row(make_item(OP_APPEND, units(4), units(0), units(0), units(0), 1'b0),
              1'b1, QUIET);
      add_row(make_item(OP_APPEND, units(4), units(4), units(0), units(0), 1'b0),
              1'b1, QUIET);
      add_row(make_item(OP_APPEND, units(0), units(4), units(0), units(0), 1'b1),
              1'b1, QUIET);
      // Straight through, wholly inside, touching a corner, along a side.
      add_row(make_item(OP_QUERY, units(-1), units(2), units(5), units(2), 1'b0),
              1'b0, QUIET);
      add_row(make_item(OP_QUERY, units(1), units(1), units(3), units(3), 1'b0),
              1'b0, QUIET);
      add_row(make_item(OP_QUERY, units(4), units(4), units(6), units(6), 1'b0),
              1'b0, QUIET);
      add_row(make_item(OP_QUERY, units(1), units(0), units(3), units(0), 1'b0),
              1'b0, QUIET);
      // A one-point polygon is never crossed, even by a segment through it.
      add_row(make_item(OP_APPEND, units(10), units(10), units(0), units(0), 1'b1),
              1'b1, QUIET);
      add_row(make_item(OP_QUERY, units(9), units(9), units(11), units(11), 1'b0),
              1'b0, QUIET);
      // An open trailing triangle still wraps back to its own first vertex.
      add_row(make_item(OP_APPEND, units(20), units(0), units(0), units(0), 1'b0),
              1'b1, QUIET);
      add_row(make_item(OP_APPEND, units(24), units(0), units(0), units(0), 1'b0),
              1'b1, QUIET);
      add_row(make_item(OP_APPEND, units(24), units(4), units(0), units(0), 1'b0),
              1'b1, QUIET);
      add_row(make_item(OP_QUERY, units(21), units(3), units(23), units(1), 1'b0),
              1'b0, QUIET);
      // A vertex at the corner of the field, then queries across the field.
      add_row(make_item(OP_APPEND, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1),
              1'b1, QUIET);
      add_row(make_item(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0),
              1'b0, QUIET);
      add_row(make_item(OP_QUERY, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1),
              1'b0, QUIET);
      // Clearing empties the table; a query after it finds nothing.
      add_row(make_item(OP_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1),
              1'b1, QUIET);
      add_row(make_item(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0),
              1'b1, QUIET);
      add_row(make_item(OP_APPEND, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1),
              1'b1, QUIET);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_item(directed_rows[r].item, directed_rows[r].answer_known,
                   directed_rows[r].answer);
      end

      // The third scene always fills the table; the others do so rarely.
      scene_index = 0;
      while (items_sent < TOTAL_ITEMS) begin
         run_scene(scene_index == 2 || $urandom_range(0, 29) == 0);
         scene_index++;
      end

      start <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      // Stay a while longer to catch any result that should never come.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("segment_polygon_crossing_check test passed");
      end else begin
         $display("segment_polygon_crossing_check test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/spcc_pkg.sv
rtl/spcc_vertex_mem.sv
rtl/spcc_edge_pipe.sv
rtl/segment_polygon_crossing_check.sv
rtl/spcc_checker.sv
tb/segment_polygon_crossing_check_test.sv
